[rtl/fph_pkg.sv]
`default_nettype none

package fph_pkg;

  localparam int DELTA_W = 15;
  localparam int DIST_W = 22;
  localparam int QUEUE_DEPTH = 4;

  localparam int HALF_PI_Q14 = 25736;
  localparam int PI_Q14 = 51472;
  localparam int CORDIC_GAIN_Q30 = 652032874;

  localparam logic signed [15:0] RESET_COEFF_SQUARE = 16'sd0;
  localparam logic signed [15:0] RESET_COEFF_LINEAR = 16'sd4096;
  localparam logic signed [15:0] RESET_COEFF_CONSTANT = 16'sd0;
  localparam logic [11:0] RESET_CENTER_ROW = 12'd1024;
  localparam logic [11:0] RESET_CENTER_COL = 12'd1124;
  localparam logic [10:0] RESET_CIRCLE_RADIUS = 11'd1024;

  typedef enum logic [2:0] {
    REG_COEFF_SQUARE   = 3'd0,
    REG_COEFF_LINEAR   = 3'd1,
    REG_COEFF_CONSTANT = 3'd2,
    REG_CENTER_ROW     = 3'd3,
    REG_CENTER_COL     = 3'd4,
    REG_CIRCLE_RADIUS  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [7:0]  blue_in;
    logic [7:0]  green_in;
    logic [7:0]  red_in;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [7:0]         blue_out;
    logic [7:0]         green_out;
    logic [7:0]         red_out;
    logic               coeff_error;
  } point_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_row;
    logic signed [DELTA_W-1:0] delta_col;
    logic [DIST_W-1:0]         dist_sq;
    logic [7:0]                blue;
    logic [7:0]                green;
    logic [7:0]                red;
  } work_t;

  typedef struct packed {
    logic signed [15:0] coeff_square;
    logic signed [15:0] coeff_linear;
    logic signed [15:0] coeff_constant;
    logic [11:0]        center_row;
    logic [11:0]        center_col;
    logic [10:0]        radius;
    logic [21:0]        radius_sq;
    logic [16:0]        den_mag;
    logic               den_neg;
    logic               den_zero;
  } cfg_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] v;
    case (i)
      0:  v = 31'd843314856;
      1:  v = 31'd497837829;
      2:  v = 31'd263043836;
      3:  v = 31'd133525158;
      4:  v = 31'd67021686;
      5:  v = 31'd33543515;
      6:  v = 31'd16775850;
      7:  v = 31'd8388437;
      8:  v = 31'd4194282;
      9:  v = 31'd2097149;
      10: v = 31'd1048575;
      11: v = 31'd524287;
      12: v = 31'd262143;
      13: v = 31'd131071;
      14: v = 31'd65535;
      15: v = 31'd32767;
      16: v = 31'd16383;
      17: v = 31'd8191;
      18: v = 31'd4095;
      19: v = 31'd2047;
      20: v = 31'd1023;
      21: v = 31'd511;
      22: v = 31'd255;
      23: v = 31'd127;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/fph_stream_if.sv]
`default_nettype none

interface fph_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/fph_front.sv]
`default_nettype none

module fph_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fph_pkg::cfg_t cfg,
  fph_stream_if.sink         pixel_in,
  fph_stream_if.source       work_out
);
  import fph_pkg::*;

  localparam int CW = COORD_BITS;

  typedef struct packed {
    logic                      valid;
    logic signed [DELTA_W-1:0] dr;
    logic signed [DELTA_W-1:0] dc;
    logic [7:0]                blue;
    logic [7:0]                green;
    logic [7:0]                red;
  } s1_t;

  typedef struct packed {
    logic                      valid;
    logic signed [DELTA_W-1:0] dr;
    logic signed [DELTA_W-1:0] dc;
    logic [29:0]               d2;
    logic [7:0]                blue;
    logic [7:0]                green;
    logic [7:0]                red;
  } s2_t;

  s1_t s1;
  s2_t s2;

  logic [CW-1:0]    row_m, col_m, crow_m, ccol_m;
  logic signed [CW:0] dr, dc;
  logic             in_circle;
  logic             f_adv;

  assign row_m  = CW'(pixel_in.data.pixel_row);
  assign col_m  = CW'(pixel_in.data.pixel_col);
  assign crow_m = CW'(cfg.center_row);
  assign ccol_m = CW'(cfg.center_col);
  assign dr = signed'({1'b0, row_m}) - signed'({1'b0, crow_m});
  assign dc = signed'({1'b0, col_m}) - signed'({1'b0, ccol_m});

  assign in_circle = (cfg.radius != 11'd0) && (s2.d2 <= 30'(cfg.radius_sq));
  // an item outside the circle is dropped and never waits on the queue
  assign f_adv = !s2.valid || !in_circle || work_out.ready;
  assign pixel_in.ready = f_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else if (f_adv) begin
      s1.valid <= pixel_in.valid;
      s1.dr    <= DELTA_W'(dr);
      s1.dc    <= DELTA_W'(dc);
      s1.blue  <= pixel_in.data.blue_in;
      s1.green <= pixel_in.data.green_in;
      s1.red   <= pixel_in.data.red_in;
      s2.valid <= s1.valid;
      s2.dr    <= s1.dr;
      s2.dc    <= s1.dc;
      s2.d2    <= 30'(s1.dr * s1.dr) + 30'(s1.dc * s1.dc);
      s2.blue  <= s1.blue;
      s2.green <= s1.green;
      s2.red   <= s1.red;
    end
  end

  assign work_out.valid          = s2.valid && in_circle;
  assign work_out.data.delta_row = s2.dr;
  assign work_out.data.delta_col = s2.dc;
  assign work_out.data.dist_sq   = DIST_W'(s2.d2);
  assign work_out.data.blue      = s2.blue;
  assign work_out.data.green     = s2.green;
  assign work_out.data.red       = s2.red;

endmodule

`default_nettype wire

[rtl/fph_queue.sv]
`default_nettype none

module fph_queue (
  input  wire logic    clk,
  input  wire logic    rst,
  fph_stream_if.sink   q_in,
  fph_stream_if.source q_out
);
  import fph_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  work_t           mem [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic            push, pop;

  assign q_in.ready  = count != CNTW'(QUEUE_DEPTH);
  assign q_out.valid = count != '0;
  assign q_out.data  = mem[rd_ptr];
  assign push = q_in.valid && q_in.ready;
  assign pop  = q_out.valid && q_out.ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= q_in.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= AW'(wr_ptr + 1'b1);
      if (pop) rd_ptr <= AW'(rd_ptr + 1'b1);
      if (push && !pop) count <= CNTW'(count + 1'b1);
      else if (pop && !push) count <= CNTW'(count - 1'b1);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CNTW'($past(count) + 1'b1)) else $error("push lost");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == CNTW'($past(count) - 1'b1)) else $error("pop lost");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr) else $error("empty queue with pointer gap");
`endif

endmodule

`default_nettype wire

[rtl/fph_back.sv]
`default_nettype none

module fph_back #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fph_pkg::cfg_t cfg,
  fph_stream_if.sink         work_in,
  fph_stream_if.source       point_out
);
  import fph_pkg::*;

  localparam int SQ_N = 15;
  localparam int TD_N = 16;
  localparam int QD_N = 15;
  localparam int XD_N = 15;
  localparam int CR_N = TRIG_ITERATIONS;

  typedef struct packed {
    logic signed [25:0] drr;
    logic signed [25:0] dcr;
    logic [14:0]        r16;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } side_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [29:0] rem;
    logic [14:0] root;
  } sq_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic        eq;
    logic [15:0] rem;
    logic [15:0] q;
  } td_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [15:0] t;
    logic [15:0] t2;
  } p1_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [33:0] bt;
    logic signed [33:0] at2;
  } p2_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [34:0] num;
  } p3_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [50:0] n;
  } p4_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic        neg;
    logic        ovf;
    logic [33:0] rem;
    logic [14:0] q;
  } qd_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic               negcos;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cr_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [33:0] cs;
    logic signed [33:0] sn;
  } o1_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic signed [59:0] px;
    logic signed [59:0] py;
    logic signed [45:0] zp;
  } o2_t;

  typedef struct packed {
    logic               valid;
    side_t              side;
    logic               zero;
    logic               negx;
    logic               negy;
    logic               ovfx;
    logic               ovfy;
    logic [33:0]        remx;
    logic [33:0]        remy;
    logic [14:0]        qx;
    logic [14:0]        qy;
    logic signed [15:0] pz;
  } xd_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sh7FFF;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

  function automatic logic signed [15:0] apply_sign(input logic neg, input logic ovf,
                                                     input logic [14:0] q);
    logic signed [15:0] r;
    if (ovf) r = neg ? 16'sh8000 : 16'sh7FFF;
    else if (neg) r = -signed'({1'b0, q});
    else r = signed'({1'b0, q});
    return r;
  endfunction

  logic adv;
  assign adv = !point_out.valid || point_out.ready;
  assign work_in.ready = adv;

  logic signed [11:0] radius_s;
  logic [14:0]        radius16;
  assign radius_s = signed'({1'b0, cfg.radius});
  assign radius16 = {cfg.radius, 4'd0};

  side_t side_in;
  always_comb begin
    side_in.drr   = 26'(work_in.data.delta_row * radius_s);
    side_in.dcr   = 26'(work_in.data.delta_col * radius_s);
    side_in.r16   = '0;
    side_in.blue  = work_in.data.blue;
    side_in.green = work_in.data.green;
    side_in.red   = work_in.data.red;
  end

  // square root of dist_sq * 256, one result bit per stage
  sq_t sq [SQ_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (adv) begin
      sq[0].valid <= work_in.valid;
      sq[0].side  <= side_in;
      sq[0].rem   <= 30'({work_in.data.dist_sq, 8'd0});
      sq[0].root  <= '0;
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    localparam int K = SQ_N - 1 - j;
    logic [30:0] trial;
    logic        take;
    assign trial = (31'(sq[j].root) << (K + 1)) + (31'(1) << (2 * K));
    assign take  = {1'b0, sq[j].rem} >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq[j+1].valid <= 1'b0;
      end else if (adv) begin
        sq[j+1].valid <= sq[j].valid;
        sq[j+1].side  <= sq[j].side;
        sq[j+1].rem   <= take ? 30'({1'b0, sq[j].rem} - trial) : sq[j].rem;
        sq[j+1].root  <= take ? (sq[j].root | (15'(1) << K)) : sq[j].root;
      end
    end
  end

  // t = (16R - r16) * 2^16 / 16R, one quotient bit per stage
  td_t   td [TD_N+1];
  side_t td_side;

  always_comb begin
    td_side     = sq[SQ_N].side;
    td_side.r16 = sq[SQ_N].root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      td[0].valid <= 1'b0;
    end else if (adv) begin
      td[0].valid <= sq[SQ_N].valid;
      td[0].side  <= td_side;
      td[0].eq    <= sq[SQ_N].root == '0;
      td[0].rem   <= 16'(radius16 - sq[SQ_N].root);
      td[0].q     <= '0;
    end
  end

  for (genvar j = 0; j < TD_N; j++) begin : g_td
    logic [16:0] rem2;
    logic        take;
    assign rem2 = {td[j].rem, 1'b0};
    assign take = rem2 >= {2'b00, radius16};
    always_ff @(posedge clk) begin
      if (rst) begin
        td[j+1].valid <= 1'b0;
      end else if (adv) begin
        td[j+1].valid <= td[j].valid;
        td[j+1].side  <= td[j].side;
        td[j+1].eq    <= td[j].eq;
        td[j+1].rem   <= 16'(take ? rem2 - {2'b00, radius16} : rem2);
        td[j+1].q     <= {td[j].q[14:0], take};
      end
    end
  end

  // polynomial in t, then scale by pi/2 over the coefficient sum
  p1_t p1;
  p2_t p2;
  p3_t p3;
  p4_t p4;
  logic [15:0] t_val;
  logic [31:0] t_sq;
  assign t_val = td[TD_N].eq ? 16'hFFFF : td[TD_N].q;
  assign t_sq  = 32'(t_val) * 32'(t_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0;
      p2.valid <= 1'b0;
      p3.valid <= 1'b0;
      p4.valid <= 1'b0;
    end else if (adv) begin
      p1.valid <= td[TD_N].valid;
      p1.side  <= td[TD_N].side;
      p1.t     <= t_val;
      p1.t2    <= t_sq[31:16];
      p2.valid <= p1.valid;
      p2.side  <= p1.side;
      p2.bt    <= 34'(cfg.coeff_linear * signed'({1'b0, p1.t}));
      p2.at2   <= 34'(cfg.coeff_square * signed'({1'b0, p1.t2}));
      p3.valid <= p2.valid;
      p3.side  <= p2.side;
      p3.num   <= 35'(p2.bt) + 35'(p2.at2) + (35'(cfg.coeff_constant) <<< 16);
      p4.valid <= p3.valid;
      p4.side  <= p3.side;
      p4.n     <= 51'(p3.num * 51'(HALF_PI_Q14));
    end
  end

  qd_t qd [QD_N+1];
  logic [50:0] n_mag;
  logic [33:0] n_shift;
  assign n_mag   = p4.n[50] ? 51'(-p4.n) : 51'(p4.n);
  assign n_shift = 34'(n_mag >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      qd[0].valid <= 1'b0;
    end else if (adv) begin
      qd[0].valid <= p4.valid;
      qd[0].side  <= p4.side;
      qd[0].neg   <= p4.n[50] ^ cfg.den_neg;
      qd[0].ovf   <= n_shift >= (34'(cfg.den_mag) << 15);
      qd[0].rem   <= n_shift;
      qd[0].q     <= '0;
    end
  end

  for (genvar j = 0; j < QD_N; j++) begin : g_qd
    localparam int K = QD_N - 1 - j;
    logic [33:0] dv;
    logic        take;
    assign dv   = 34'(cfg.den_mag) << K;
    assign take = qd[j].rem >= dv;
    always_ff @(posedge clk) begin
      if (rst) begin
        qd[j+1].valid <= 1'b0;
      end else if (adv) begin
        qd[j+1].valid <= qd[j].valid;
        qd[j+1].side  <= qd[j].side;
        qd[j+1].neg   <= qd[j].neg;
        qd[j+1].ovf   <= qd[j].ovf;
        qd[j+1].rem   <= take ? qd[j].rem - dv : qd[j].rem;
        qd[j+1].q     <= take ? (qd[j].q | (15'(1) << K)) : qd[j].q;
      end
    end
  end

  // fold theta into the first or fourth quadrant for the rotation
  logic signed [15:0] theta;
  logic signed [17:0] th_fold;
  logic               negcos;
  always_comb begin
    if (cfg.den_zero) theta = '0;
    else theta = apply_sign(qd[QD_N].neg, qd[QD_N].ovf, qd[QD_N].q);
    th_fold = 18'(theta);
    negcos  = 1'b0;
    if (th_fold > 18'(HALF_PI_Q14)) begin
      th_fold = 18'(PI_Q14) - 18'(theta);
      negcos  = 1'b1;
    end else if (th_fold < -18'(HALF_PI_Q14)) begin
      th_fold = -18'(PI_Q14) - 18'(theta);
      negcos  = 1'b1;
    end
  end

  cr_t cr [CR_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cr[0].valid <= 1'b0;
    end else if (adv) begin
      cr[0].valid  <= qd[QD_N].valid;
      cr[0].side   <= qd[QD_N].side;
      cr[0].negcos <= negcos;
      cr[0].x      <= 34'(CORDIC_GAIN_Q30);
      cr[0].y      <= '0;
      cr[0].z      <= 34'(th_fold) <<< 16;
    end
  end

  for (genvar i = 0; i < CR_N; i++) begin : g_cr
    localparam logic signed [33:0] ANGLE = 34'(atan_q30(i));
    logic signed [33:0] xs, ys;
    assign xs = cr[i].x >>> i;
    assign ys = cr[i].y >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        cr[i+1].valid <= 1'b0;
      end else if (adv) begin
        cr[i+1].valid  <= cr[i].valid;
        cr[i+1].side   <= cr[i].side;
        cr[i+1].negcos <= cr[i].negcos;
        if (!cr[i].z[33]) begin
          cr[i+1].x <= cr[i].x - ys;
          cr[i+1].y <= cr[i].y + xs;
          cr[i+1].z <= cr[i].z - ANGLE;
        end else begin
          cr[i+1].x <= cr[i].x + ys;
          cr[i+1].y <= cr[i].y - xs;
          cr[i+1].z <= cr[i].z + ANGLE;
        end
      end
    end
  end

  // scale by R*cos/r16 and R*sin
  o1_t o1;
  o2_t o2;
  xd_t xd [XD_N+1];
  logic [59:0] px_mag, py_mag;
  logic [33:0] mx, my;
  assign px_mag = o2.px[59] ? 60'(-o2.px) : 60'(o2.px);
  assign py_mag = o2.py[59] ? 60'(-o2.py) : 60'(o2.py);
  assign mx = 34'(px_mag >> 22);
  assign my = 34'(py_mag >> 22);

  always_ff @(posedge clk) begin
    if (rst) begin
      o1.valid    <= 1'b0;
      o2.valid    <= 1'b0;
      xd[0].valid <= 1'b0;
    end else if (adv) begin
      o1.valid <= cr[CR_N].valid;
      o1.side  <= cr[CR_N].side;
      o1.cs    <= cr[CR_N].negcos ? -cr[CR_N].x : cr[CR_N].x;
      o1.sn    <= cr[CR_N].y;
      o2.valid <= o1.valid;
      o2.side  <= o1.side;
      o2.px    <= 60'(o1.side.drr * o1.cs);
      o2.py    <= 60'(o1.side.dcr * o1.cs);
      o2.zp    <= 46'(radius_s * o1.sn);
      xd[0].valid <= o2.valid;
      xd[0].side  <= o2.side;
      xd[0].zero  <= o2.side.r16 == '0;
      xd[0].negx  <= o2.px[59];
      xd[0].negy  <= o2.py[59];
      xd[0].ovfx  <= mx >= (34'(o2.side.r16) << 15);
      xd[0].ovfy  <= my >= (34'(o2.side.r16) << 15);
      xd[0].remx  <= mx;
      xd[0].remy  <= my;
      xd[0].qx    <= '0;
      xd[0].qy    <= '0;
      xd[0].pz    <= sat16(20'(o2.zp >>> 26));
    end
  end

  for (genvar j = 0; j < XD_N; j++) begin : g_xd
    localparam int K = XD_N - 1 - j;
    logic [33:0] dv;
    logic        take_x, take_y;
    assign dv     = 34'(xd[j].side.r16) << K;
    assign take_x = xd[j].remx >= dv;
    assign take_y = xd[j].remy >= dv;
    always_ff @(posedge clk) begin
      if (rst) begin
        xd[j+1].valid <= 1'b0;
      end else if (adv) begin
        xd[j+1].valid <= xd[j].valid;
        xd[j+1].side  <= xd[j].side;
        xd[j+1].zero  <= xd[j].zero;
        xd[j+1].negx  <= xd[j].negx;
        xd[j+1].negy  <= xd[j].negy;
        xd[j+1].ovfx  <= xd[j].ovfx;
        xd[j+1].ovfy  <= xd[j].ovfy;
        xd[j+1].pz    <= xd[j].pz;
        xd[j+1].remx  <= take_x ? xd[j].remx - dv : xd[j].remx;
        xd[j+1].remy  <= take_y ? xd[j].remy - dv : xd[j].remy;
        xd[j+1].qx    <= take_x ? (xd[j].qx | (15'(1) << K)) : xd[j].qx;
        xd[j+1].qy    <= take_y ? (xd[j].qy | (15'(1) << K)) : xd[j].qy;
      end
    end
  end

  // output register: hold while the sink stalls
  point_t out_data;
  logic   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= xd[XD_N].valid;
      if (xd[XD_N].zero) begin
        out_data.point_x <= '0;
        out_data.point_y <= '0;
      end else begin
        out_data.point_x <= apply_sign(xd[XD_N].negx, xd[XD_N].ovfx, xd[XD_N].qx);
        out_data.point_y <= apply_sign(xd[XD_N].negy, xd[XD_N].ovfy, xd[XD_N].qy);
      end
      out_data.point_z     <= xd[XD_N].pz;
      out_data.blue_out    <= xd[XD_N].side.blue;
      out_data.green_out   <= xd[XD_N].side.green;
      out_data.red_out     <= xd[XD_N].side.red;
      out_data.coeff_error <= cfg.den_zero;
    end
  end

  assign point_out.valid = out_valid;
  assign point_out.data  = out_data;

endmodule

`default_nettype wire

[rtl/fisheye_pixel_to_hemisphere.sv]
`default_nettype none

// A pixel passes the front stages, the queue, the square root, the t divider, the
// polynomial, the angle divider, the rotation, the scaling and the output register.
// Throughput: one pixel per cycle while the point sink accepts, set by the fully
// pipelined square root, the bit-per-stage dividers and the one-stage-per-iteration rotation.
// Pixels outside the image circle leave after the front stages and give no point.
// Synchronous active-high reset empties the pipeline and queue and loads default registers.
module fisheye_pixel_to_hemisphere #(
  parameter int COORD_BITS = 12,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [2:0]  write_index,
  input  wire logic [15:0] write_data,
  fph_stream_if.sink       pixel_in,
  fph_stream_if.source     point_out
);
  import fph_pkg::*;

  logic signed [15:0] coeff_square, coeff_linear, coeff_constant;
  logic [11:0]        center_row, center_col;
  logic [10:0]        circle_radius;
  logic signed [17:0] den;
  cfg_t               cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_square   <= RESET_COEFF_SQUARE;
      coeff_linear   <= RESET_COEFF_LINEAR;
      coeff_constant <= RESET_COEFF_CONSTANT;
      center_row     <= RESET_CENTER_ROW;
      center_col     <= RESET_CENTER_COL;
      circle_radius  <= RESET_CIRCLE_RADIUS;
    end else if (write_enable) begin
      unique case (write_index)
        REG_COEFF_SQUARE:   coeff_square   <= write_data;
        REG_COEFF_LINEAR:   coeff_linear   <= write_data;
        REG_COEFF_CONSTANT: coeff_constant <= write_data;
        REG_CENTER_ROW:     center_row     <= write_data[11:0];
        REG_CENTER_COL:     center_col     <= write_data[11:0];
        REG_CIRCLE_RADIUS:  circle_radius  <= write_data[10:0];
        default: ;
      endcase
    end
  end

  assign den = 18'(coeff_square) + 18'(coeff_linear) + 18'(coeff_constant);

  always_comb begin
    cfg.coeff_square   = coeff_square;
    cfg.coeff_linear   = coeff_linear;
    cfg.coeff_constant = coeff_constant;
    cfg.center_row     = center_row;
    cfg.center_col     = center_col;
    cfg.radius         = circle_radius;
    cfg.radius_sq      = 22'(circle_radius) * 22'(circle_radius);
    cfg.den_mag        = den[17] ? 17'(-den) : 17'(den);
    cfg.den_neg        = den[17];
    cfg.den_zero       = den == '0;
  end

  fph_stream_if #(.payload_t(work_t)) q_wr ();
  fph_stream_if #(.payload_t(work_t)) q_rd ();

  fph_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pixel_in (pixel_in),
    .work_out (q_wr)
  );

  fph_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .q_in  (q_wr),
    .q_out (q_rd)
  );

  fph_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .work_in   (q_rd),
    .point_out (point_out)
  );

endmodule

`default_nettype wire
